[hw/rtl/fwrt_pkg.sv]
package fwrt_pkg;

    localparam int unsigned DEPTH  = 64;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned CNT_W  = IDX_W + 1;
    localparam int unsigned GROUP  = 8;
    localparam int unsigned NGROUP = DEPTH / GROUP;
    localparam int unsigned GSEL_W = $clog2(GROUP);
    localparam int unsigned GNUM_W = IDX_W - GSEL_W;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] w3;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w0;
    } t_rec;

    typedef struct packed {
        logic              valid;
        t_cmd              cmd;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] key;
        logic [1:0]        col;
        logic [CNT_W-1:0]  count;
        t_rec              rec;
    } t_op;

endpackage

[hw/rtl/four_word_record_table.sv]
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_stall   i_cmd, i_word_*, i_entry_index, i_search_key, i_column
// output    out        o_valid / i_stall   o_status, o_found_index, o_out_*, o_entry_count
//
// One word is accepted per cycle while o_stall is low.
// Each result passes through the cell row, one registered group reduction and the output register.
// At the accepting edge, append writes the cell at the record count and remove shifts the cells from the index on.
// Reset clears the record count and the pipeline valids; stored records are not cleared.
// A stalled output holds the result while the input keeps accepting until the pipeline fills.
module four_word_record_table (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_cmd,
    input  logic [fwrt_pkg::WORD_W-1:0]           i_word_zero,
    input  logic [fwrt_pkg::WORD_W-1:0]           i_word_one,
    input  logic [fwrt_pkg::WORD_W-1:0]           i_word_two,
    input  logic [fwrt_pkg::WORD_W-1:0]           i_word_three,
    input  logic [fwrt_pkg::IDX_W-1:0]            i_entry_index,
    input  logic [fwrt_pkg::WORD_W-1:0]           i_search_key,
    input  logic [1:0]                            i_column,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [1:0]                            o_status,
    output logic [fwrt_pkg::IDX_W-1:0]            o_found_index,
    output logic [fwrt_pkg::WORD_W-1:0]           o_out_zero,
    output logic [fwrt_pkg::WORD_W-1:0]           o_out_one,
    output logic [fwrt_pkg::WORD_W-1:0]           o_out_two,
    output logic [fwrt_pkg::WORD_W-1:0]           o_out_three,
    output logic [fwrt_pkg::CNT_W-1:0]            o_entry_count
);

    logic                                   accept;
    logic                                   adv2;
    logic                                   adv3;
    logic                                   r_v1;
    logic                                   r_v2;
    logic                                   r_v3;
    logic [fwrt_pkg::CNT_W-1:0]             r_count;
    logic [fwrt_pkg::CNT_W-1:0]             n_count;
    fwrt_pkg::t_status                      n_status;
    fwrt_pkg::t_cmd                         r1_cmd;
    fwrt_pkg::t_status                      r1_status;
    logic [fwrt_pkg::CNT_W-1:0]             r1_count;
    fwrt_pkg::t_cmd                         r2_cmd;
    fwrt_pkg::t_status                      r2_status;
    logic [fwrt_pkg::CNT_W-1:0]             r2_count;
    fwrt_pkg::t_status                      r3_status;
    logic [fwrt_pkg::IDX_W-1:0]             r3_found;
    fwrt_pkg::t_rec                         r3_rec;
    logic [fwrt_pkg::CNT_W-1:0]             r3_count;
    fwrt_pkg::t_op                          op;
    fwrt_pkg::t_rec                         w_cell [fwrt_pkg::DEPTH];
    logic [fwrt_pkg::DEPTH-1:0]             w_hit;
    fwrt_pkg::t_rec [fwrt_pkg::DEPTH-1:0]   w_rd;
    logic [fwrt_pkg::NGROUP-1:0]            g_any;
    logic [fwrt_pkg::GSEL_W-1:0]            g_first [fwrt_pkg::NGROUP];
    fwrt_pkg::t_rec                         g_rec [fwrt_pkg::NGROUP];
    logic [fwrt_pkg::GNUM_W-1:0]            sel_g;
    fwrt_pkg::t_rec                         or_rec;
    logic                                   idx_in;

    assign o_stall = r_v1 && r_v2 && !adv3;
    assign accept  = i_valid && !o_stall;
    assign adv3    = r_v2 && (!r_v3 || !i_stall);
    assign adv2    = r_v1 && (!r_v2 || adv3);
    assign idx_in  = {1'b0, i_entry_index} < r_count;

    always_comb begin
        n_count  = r_count;
        n_status = fwrt_pkg::ST_OK;
        case (fwrt_pkg::t_cmd'(i_cmd))
            fwrt_pkg::CMD_APPEND: begin
                if (r_count >= fwrt_pkg::CNT_W'(fwrt_pkg::DEPTH)) begin
                    n_status = fwrt_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            fwrt_pkg::CMD_REMOVE: begin
                if (!idx_in) begin
                    n_status = fwrt_pkg::ST_RANGE;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            fwrt_pkg::CMD_READ: begin
                if (!idx_in) begin
                    n_status = fwrt_pkg::ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    assign op.valid  = accept;
    assign op.cmd    = fwrt_pkg::t_cmd'(i_cmd);
    assign op.idx    = i_entry_index;
    assign op.key    = i_search_key;
    assign op.col    = i_column;
    assign op.count  = r_count;
    assign op.rec.w0 = i_word_zero;
    assign op.rec.w1 = i_word_one;
    assign op.rec.w2 = i_word_two;
    assign op.rec.w3 = i_word_three;

    for (genvar c = 0; c < fwrt_pkg::DEPTH; c++) begin : g_cell
        fwrt_pkg::t_rec nb;
        if (c == fwrt_pkg::DEPTH - 1) begin : g_last
            assign nb = '0;
        end else begin : g_mid
            assign nb = w_cell[c + 1];
        end
        fwrt_cell u_cell (
            .i_clk  (i_clk),
            .i_pos  (fwrt_pkg::IDX_W'(c)),
            .i_op   (op),
            .i_next (nb),
            .o_rec  (w_cell[c]),
            .o_hit  (w_hit[c]),
            .o_rd   (w_rd[c])
        );
    end

    for (genvar g = 0; g < fwrt_pkg::NGROUP; g++) begin : g_grp
        fwrt_group u_group (
            .i_clk   (i_clk),
            .i_load  (adv2),
            .i_hits  (w_hit[g*fwrt_pkg::GROUP +: fwrt_pkg::GROUP]),
            .i_recs  (w_rd[g*fwrt_pkg::GROUP +: fwrt_pkg::GROUP]),
            .o_any   (g_any[g]),
            .o_first (g_first[g]),
            .o_rec   (g_rec[g])
        );
    end

    always_comb begin
        sel_g  = '0;
        or_rec = '0;
        for (int k = fwrt_pkg::NGROUP - 1; k >= 0; k--) begin
            if (g_any[k]) begin
                sel_g = fwrt_pkg::GNUM_W'(k);
            end
            or_rec = or_rec | g_rec[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_v1      <= 1'b1;
                r_count   <= n_count;
                r1_cmd    <= op.cmd;
                r1_status <= n_status;
                r1_count  <= n_count;
            end else if (adv2) begin
                r_v1 <= 1'b0;
            end
            if (adv2) begin
                r_v2      <= 1'b1;
                r2_cmd    <= r1_cmd;
                r2_status <= r1_status;
                r2_count  <= r1_count;
            end else if (adv3) begin
                r_v2 <= 1'b0;
            end
            if (adv3) begin
                r_v3     <= 1'b1;
                r3_count <= r2_count;
                r3_rec   <= or_rec;
                if (r2_cmd == fwrt_pkg::CMD_SEARCH) begin
                    r3_status <= (|g_any) ? fwrt_pkg::ST_OK : fwrt_pkg::ST_NOT_FOUND;
                    r3_found  <= (|g_any) ? {sel_g, g_first[sel_g]} : '0;
                end else begin
                    r3_status <= r2_status;
                    r3_found  <= '0;
                end
            end else if (!i_stall) begin
                r_v3 <= 1'b0;
            end
        end
    end

    assign o_valid       = r_v3;
    assign o_status      = r3_status;
    assign o_found_index = r3_found;
    assign o_out_zero    = r3_rec.w0;
    assign o_out_one     = r3_rec.w1;
    assign o_out_two     = r3_rec.w2;
    assign o_out_three   = r3_rec.w3;
    assign o_entry_count = r3_count;

`ifndef NO_ASSERTIONS
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("input stalled with an empty cell stage");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fwrt_pkg::CNT_W'(fwrt_pkg::DEPTH))
        else $error("record count beyond table depth");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_found_index != '0) |-> (o_status == fwrt_pkg::ST_OK))
        else $error("found index given without success status");

    a_count_moves_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("record count changed without an accepted word");
`endif

endmodule

[hw/rtl/fwrt_cell.sv]
module fwrt_cell (
    input  logic                          i_clk,
    input  logic [fwrt_pkg::IDX_W-1:0]    i_pos,
    input  fwrt_pkg::t_op                 i_op,
    input  fwrt_pkg::t_rec                i_next,
    output fwrt_pkg::t_rec                o_rec,
    output logic                          o_hit,
    output fwrt_pkg::t_rec                o_rd
);

    fwrt_pkg::t_rec                  r_rec;
    logic                            r_hit;
    fwrt_pkg::t_rec                  r_rd;
    logic                            pos_in;
    logic                            at_idx;
    logic                            idx_in;
    logic                            at_end;
    logic [fwrt_pkg::WORD_W-1:0]     sel_word;
    logic                            n_hit;
    logic                            rd_hit;

    assign pos_in = {1'b0, i_pos} < i_op.count;
    assign at_idx = i_pos == i_op.idx;
    assign idx_in = {1'b0, i_op.idx} < i_op.count;
    assign at_end = {1'b0, i_pos} == i_op.count;

    always_comb begin
        case (i_op.col)
            2'd0:    sel_word = r_rec.w0;
            2'd1:    sel_word = r_rec.w1;
            2'd2:    sel_word = r_rec.w2;
            default: sel_word = r_rec.w3;
        endcase
    end

    assign rd_hit = (i_op.cmd == fwrt_pkg::CMD_READ) && at_idx && idx_in;
    assign n_hit  = ((i_op.cmd == fwrt_pkg::CMD_SEARCH) && pos_in && (sel_word == i_op.key))
                    || rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_op.valid) begin
            case (i_op.cmd)
                fwrt_pkg::CMD_APPEND: begin
                    if (at_end) begin
                        r_rec <= i_op.rec;
                    end
                end
                fwrt_pkg::CMD_REMOVE: begin
                    if (idx_in && (i_pos >= i_op.idx)) begin
                        r_rec <= i_next;
                    end
                end
                default: begin
                end
            endcase
            r_hit <= n_hit;
            r_rd  <= rd_hit ? r_rec : '0;
        end
    end

    assign o_rec = r_rec;
    assign o_hit = r_hit;
    assign o_rd  = r_rd;

endmodule

[hw/rtl/fwrt_group.sv]
module fwrt_group (
    input  logic                                      i_clk,
    input  logic                                      i_load,
    input  logic [fwrt_pkg::GROUP-1:0]                i_hits,
    input  fwrt_pkg::t_rec [fwrt_pkg::GROUP-1:0]      i_recs,
    output logic                                      o_any,
    output logic [fwrt_pkg::GSEL_W-1:0]               o_first,
    output fwrt_pkg::t_rec                            o_rec
);

    logic                            r_any;
    logic [fwrt_pkg::GSEL_W-1:0]     r_first;
    fwrt_pkg::t_rec                  r_rec;
    logic [fwrt_pkg::GSEL_W-1:0]     n_first;
    fwrt_pkg::t_rec                  n_rec;

    always_comb begin
        n_first = '0;
        n_rec   = '0;
        for (int k = fwrt_pkg::GROUP - 1; k >= 0; k--) begin
            if (i_hits[k]) begin
                n_first = fwrt_pkg::GSEL_W'(k);
            end
            n_rec = n_rec | i_recs[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_any   <= |i_hits;
            r_first <= n_first;
            r_rec   <= n_rec;
        end
    end

    assign o_any   = r_any;
    assign o_first = r_first;
    assign o_rec   = r_rec;

endmodule
